>>> rtl/cht_pkg.sv
// Package for the chained hash table: request and response payloads,
// request and status codes, and the controller/datapath command structs.
// No dependencies.
package cht_pkg;

   localparam int unsigned KEY_W      = 31;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned REQ_W      = 2;
   // Key is reduced one byte per step, most significant byte first
   localparam int unsigned KEY_BYTES  = 4;
   localparam int unsigned BYTE_CNT_W = 2;

   // Request codes; any other code behaves as a search
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                is_empty;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic hash_step;
      logic scan_step;
      logic commit;
      logic respond;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic hash_done;
      logic scan_last;
   } flags_type;

endpackage

>>> rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cht_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cht_ctrl.sv
// Controller for the chained hash table: sequences clear, hash, bucket scan,
// write-back and response. Depends on cht_pkg.
module cht_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cht_pkg::cmd_type   cmd,
   input  cht_pkg::flags_type flags
);

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      HASH,
      SCAN,
      DRAIN,
      COMMIT,
      RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd            = '0;
      state_in       = state_ff;
      case (state_ff)
         CLEAR: begin
            cmd.clear_step = 1'b1;
            if (flags.clear_done) state_in = IDLE;
         end
         IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = HASH;
            end
         end
         HASH: begin
            cmd.hash_step = 1'b1;
            if (flags.hash_done) state_in = SCAN;
         end
         SCAN: begin
            cmd.scan_step = 1'b1;
            if (flags.scan_last) state_in = DRAIN;
         end
         DRAIN: begin
            state_in = COMMIT;
         end
         COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = RESP;
         end
         RESP: begin
            if (out_free) begin
               cmd.respond = 1'b1;
               state_in    = IDLE;
            end
         end
         default: begin
            state_in = CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/cht_datapath.sv
// Datapath for the chained hash table: key reduction modulo the bucket
// count, slot scan over the key RAM, write-back and response register.
// Depends on cht_pkg and cht_ram.
module cht_datapath #(
   parameter int unsigned BUCKETS          = 26,
   parameter int unsigned SLOTS_PER_BUCKET = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cht_pkg::cmd_type         cmd,
   input  cht_pkg::req_payload_type req_payload,
   output cht_pkg::flags_type       flags,
   output cht_pkg::rsp_payload_type rsp_payload
);

   localparam int unsigned ENTRIES = BUCKETS * SLOTS_PER_BUCKET;
   localparam int unsigned AW      = $clog2(ENTRIES);
   localparam int unsigned BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned TW      = BW + 8;
   localparam int unsigned SW      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int unsigned LW      = $clog2(ENTRIES + 1);
   localparam int unsigned KRAM_W  = cht_pkg::KEY_W + 1;
   localparam logic [TW-1:0] BK    = TW'(BUCKETS);

   // Request held for the whole operation
   logic [cht_pkg::REQ_W-1:0]      type_ff;
   logic [cht_pkg::KEY_W-1:0]      key_ff;
   logic [cht_pkg::VALUE_W-1:0]    value_ff;

   // Hash reduction
   logic [BW-1:0]                  rem_ff, rem_in;
   logic [cht_pkg::BYTE_CNT_W-1:0] byte_cnt_ff;
   logic [cht_pkg::KEY_W:0]        key_pad;
   logic [7:0]                     key_byte;

   // Scan
   logic [SW-1:0]                  scan_cnt_ff;
   logic                           cmp_vld_ff;
   logic [SW-1:0]                  cmp_slot_ff;
   logic                           hit_ff, free_ff;
   logic [SW-1:0]                  hit_slot_ff, free_slot_ff;
   logic [AW-1:0]                  base_addr;
   logic [KRAM_W-1:0]              kram_rd_data;
   logic                           rd_valid;
   logic [cht_pkg::KEY_W-1:0]      rd_key;

   // Write-back and bookkeeping
   logic [LW-1:0]                  live_ff, live_in;
   logic [cht_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [AW-1:0]                  clr_addr_ff;
   logic                           kram_we, vram_we;
   logic [AW-1:0]                  kram_waddr, vram_waddr, commit_addr;
   logic [KRAM_W-1:0]              kram_wdata;
   logic                           commit_kwe, commit_vwe;
   logic [KRAM_W-1:0]              commit_kdata;
   cht_pkg::rsp_payload_type       rsp_ff;

   // Reduce one key byte: remainder times 256 plus byte, then restoring
   // subtraction of BUCKETS shifted down from 128 to 1
   assign key_pad  = {1'b0, key_ff};
   assign key_byte = key_pad[8 * (cht_pkg::KEY_BYTES - 1 - 32'(byte_cnt_ff)) +: 8];

   always_comb begin
      logic [TW-1:0] t;
      t = {rem_ff, key_byte};
      for (int i = 7; i >= 0; i--) begin
         if (t >= (BK << i)) t = t - (BK << i);
      end
      rem_in = t[BW-1:0];
   end

   assign base_addr = AW'(rem_ff) * AW'(SLOTS_PER_BUCKET);

   assign rd_valid = kram_rd_data[KRAM_W-1];
   assign rd_key   = kram_rd_data[cht_pkg::KEY_W-1:0];

   // Decide the outcome from the scan results
   always_comb begin
      commit_kwe   = 1'b0;
      commit_vwe   = 1'b0;
      commit_addr  = base_addr + AW'(hit_slot_ff);
      commit_kdata = {1'b0, key_ff};
      live_in      = live_ff;
      status_in    = hit_ff ? cht_pkg::ST_FOUND : cht_pkg::ST_NOT_FOUND;
      case (type_ff)
         cht_pkg::REQ_INSERT: begin
            if (hit_ff) begin
               commit_vwe = 1'b1;
               status_in  = cht_pkg::ST_REPLACED;
            end else if (free_ff) begin
               commit_addr  = base_addr + AW'(free_slot_ff);
               commit_kwe   = 1'b1;
               commit_vwe   = 1'b1;
               commit_kdata = {1'b1, key_ff};
               live_in      = live_ff + LW'(1);
               status_in    = cht_pkg::ST_INSERTED;
            end else begin
               status_in = cht_pkg::ST_FULL;
            end
         end
         cht_pkg::REQ_REMOVE: begin
            if (hit_ff) begin
               commit_kwe = 1'b1;
               if (live_ff != '0) live_in = live_ff - LW'(1);
               status_in = cht_pkg::ST_REMOVED;
            end else begin
               status_in = cht_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            // search and the unused code: status default above
         end
      endcase
   end

   // Key RAM write port: clearing pass or write-back
   always_comb begin
      if (cmd.clear_step) begin
         kram_we    = 1'b1;
         kram_waddr = clr_addr_ff;
         kram_wdata = '0;
      end else begin
         kram_we    = cmd.commit && commit_kwe;
         kram_waddr = commit_addr;
         kram_wdata = commit_kdata;
      end
   end

   assign vram_we    = cmd.commit && commit_vwe;
   assign vram_waddr = commit_addr;

   cht_ram #(
      .WIDTH (KRAM_W),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (kram_we),
      .wr_addr (kram_waddr),
      .wr_data (kram_wdata),
      .rd_en   (cmd.scan_step),
      .rd_addr (base_addr + AW'(scan_cnt_ff)),
      .rd_data (kram_rd_data)
   );

   cht_ram #(
      .WIDTH (cht_pkg::VALUE_W),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (vram_we),
      .wr_addr (vram_waddr),
      .wr_data (value_ff),
      .rd_en   (1'b0),
      .rd_addr (vram_waddr),
      .rd_data ()
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         live_ff     <= '0;
         cmp_vld_ff  <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_addr_ff <= clr_addr_ff + AW'(1);
         if (cmd.commit) live_ff <= live_in;
         cmp_vld_ff <= cmd.scan_step;
      end
   end

   // Operation payload and scan trackers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff     <= req_payload.req_type;
         key_ff      <= req_payload.key;
         value_ff    <= req_payload.value;
         rem_ff      <= '0;
         byte_cnt_ff <= '0;
         scan_cnt_ff <= '0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
      end else begin
         if (cmd.hash_step) begin
            rem_ff      <= rem_in;
            byte_cnt_ff <= byte_cnt_ff + cht_pkg::BYTE_CNT_W'(1);
         end
         if (cmd.scan_step) scan_cnt_ff <= scan_cnt_ff + SW'(1);
         if (cmp_vld_ff) begin
            if (rd_valid && (rd_key == key_ff) && !hit_ff) begin
               hit_ff      <= 1'b1;
               hit_slot_ff <= cmp_slot_ff;
            end
            if (!rd_valid && !free_ff) begin
               free_ff      <= 1'b1;
               free_slot_ff <= cmp_slot_ff;
            end
         end
      end
      cmp_slot_ff <= scan_cnt_ff;
      if (cmd.commit) status_ff <= status_in;
      if (cmd.respond) begin
         rsp_ff.status   <= status_ff;
         rsp_ff.is_empty <= (live_ff == '0);
      end
   end

   assign flags.clear_done = (clr_addr_ff == AW'(ENTRIES - 1));
   assign flags.hash_done  = (byte_cnt_ff == cht_pkg::BYTE_CNT_W'(cht_pkg::KEY_BYTES - 1));
   assign flags.scan_last  = (scan_cnt_ff == SW'(SLOTS_PER_BUCKET - 1));

   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/chained_hash_table.sv
// Chained hash table: BUCKETS buckets of SLOTS_PER_BUCKET slots, key mod BUCKETS.
// Each request passes through 4 key-reduction steps, one key RAM read per slot,
// drain, write-back and response; the next request is taken only once the
// previous one has left the response state.
// Reset: synchronous; a clearing pass over all BUCKETS*SLOTS_PER_BUCKET entries then
// wipes the valid marks in the key RAM, holding req_stall high until it ends.
module chained_hash_table #(
   parameter int unsigned BUCKETS          = 26,
   parameter int unsigned SLOTS_PER_BUCKET = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // Request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cht_pkg::req_payload_type req_payload,
   // Response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cht_pkg::rsp_payload_type rsp_payload
);

   // Commands and status between the sequencer and the datapath
   cht_pkg::cmd_type   cmd;
   cht_pkg::flags_type flags;

   // The controller takes one request at a time. A finished response sits in
   // the output register, so the next request is taken while it waits; that
   // request's own response is held in the response state until the register
   // frees up.
   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .flags     (flags)
   );

   // The datapath reduces the key a byte per cycle, walks the bucket's slots
   // through the registered key RAM, records the first match and the lowest
   // free slot, then writes back and updates the live entry count.
   cht_datapath #(
      .BUCKETS          (BUCKETS),
      .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .flags       (flags),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> bench/chained_hash_table_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for chained_hash_table: drives insert, remove and search requests
// and checks every response against a scoreboard that tracks the table's contents.
// Depends on cht_pkg and the chained_hash_table RTL.
module chained_hash_table_tb;

   localparam int unsigned BUCKETS          = 26;
   localparam int unsigned SLOTS_PER_BUCKET = 8;
   localparam int unsigned ENTRIES          = BUCKETS * SLOTS_PER_BUCKET;
   // Request code 3 is unused by the block and must behave as a search
   localparam logic [cht_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;
   localparam logic [cht_pkg::KEY_W-1:0] KEY_MAX   = {cht_pkg::KEY_W{1'b1}};
   // Requests sent in the whole run, directed ones included
   localparam int unsigned TOTAL_ITEMS      = 1950;
   // Longest hold-off of the response side, used to push the block into back-pressure
   localparam int unsigned LONG_HOLD        = 600;
   // Cycles with no handshake on either channel before the run is abandoned
   localparam int unsigned QUIET_LIMIT      = 5000;
   localparam int unsigned TAIL_CYCLES      = 40;

   // Scoreboard: mirrors slot occupancy per bucket and queues the expected responses.
   // Values are not observable at the response port, so only keys and valid marks are kept.
   class cht_scoreboard;
      bit [cht_pkg::KEY_W-1:0]  slot_key  [ENTRIES];
      bit                       slot_live [ENTRIES];
      int unsigned              live_entries;
      cht_pkg::rsp_payload_type expected_q [$];
      int unsigned              errors;

      function new();
         foreach (slot_live[i]) slot_live[i] = 1'b0;
         live_entries = 0;
         errors       = 0;
      endfunction

      // Apply an accepted request to the mirror and queue its response
      function void note_request(cht_pkg::req_payload_type r);
         int unsigned              base;
         int                       hit;
         int                       free_slot;
         cht_pkg::rsp_payload_type e;
         base      = (r.key % BUCKETS) * SLOTS_PER_BUCKET;
         hit       = -1;
         free_slot = -1;
         e         = '0;
         for (int unsigned s = 0; s < SLOTS_PER_BUCKET; s++) begin
            if (slot_live[base+s] && slot_key[base+s] == r.key && hit < 0)
               hit = int'(base + s);
            if (!slot_live[base+s] && free_slot < 0)
               free_slot = int'(base + s);
         end
         case (r.req_type)
            cht_pkg::REQ_INSERT: begin
               if (hit >= 0) begin
                  e.status = cht_pkg::ST_REPLACED;
               end else if (free_slot >= 0) begin
                  slot_key[free_slot]  = r.key;
                  slot_live[free_slot] = 1'b1;
                  live_entries++;
                  e.status = cht_pkg::ST_INSERTED;
               end else begin
                  e.status = cht_pkg::ST_FULL;
               end
            end
            cht_pkg::REQ_REMOVE: begin
               if (hit >= 0) begin
                  slot_live[hit] = 1'b0;
                  if (live_entries > 0) live_entries--;
                  e.status = cht_pkg::ST_REMOVED;
               end else begin
                  e.status = cht_pkg::ST_NOT_FOUND;
               end
            end
            default: e.status = (hit >= 0) ? cht_pkg::ST_FOUND : cht_pkg::ST_NOT_FOUND;
         endcase
         e.is_empty = (live_entries == 0);
         expected_q.push_back(e);
      endfunction

      // Compare an accepted response with the oldest expectation
      function void check_response(cht_pkg::rsp_payload_type got);
         cht_pkg::rsp_payload_type e;
         if (expected_q.size() == 0) begin
            $error("response with nothing expected: status %0d is_empty %0d",
                   got.status, got.is_empty);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            errors++;
         end
         if (got.is_empty !== e.is_empty) begin
            $error("is_empty: expected %0d, got %0d", e.is_empty, got.is_empty);
            errors++;
         end
      endfunction
   endclass

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   cht_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   cht_pkg::rsp_payload_type rsp_payload;

   cht_scoreboard book = new();
   // Raised by the stimulus to ask the response side for one long hold-off
   bit long_hold_req = 1'b0;

   chained_hash_table #(
      .BUCKETS          (BUCKETS),
      .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic cht_pkg::req_payload_type make_request(
         logic [cht_pkg::REQ_W-1:0]   kind,
         logic [cht_pkg::KEY_W-1:0]   key,
         logic [cht_pkg::VALUE_W-1:0] value);
      cht_pkg::req_payload_type r;
      r.req_type = kind;
      r.key      = key;
      r.value    = value;
      return r;
   endfunction

   // Idle cycles before the next request: mostly none or short, now and then long
   function automatic int unsigned next_gap(bit busy);
      int unsigned r;
      if (busy) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // Random request aimed at a few neighbouring buckets, so that keys collide,
   // buckets fill up and removes hit; the rest are wide-range keys or keys just below KEY_MAX.
   function automatic cht_pkg::req_payload_type pick_request(int unsigned b0,
                                                             int unsigned nb,
                                                             bit remove_heavy);
      int unsigned               r;
      int unsigned               bucket;
      logic [cht_pkg::KEY_W-1:0] key;
      logic [cht_pkg::REQ_W-1:0] kind;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         bucket = (b0 + $urandom_range(0, nb - 1)) % BUCKETS;
         key    = cht_pkg::KEY_W'(bucket + BUCKETS * $urandom_range(0, 11));
      end else if (r < 92) begin
         key = cht_pkg::KEY_W'($urandom());
      end else begin
         key = KEY_MAX - cht_pkg::KEY_W'($urandom_range(0, 3 * BUCKETS));
      end
      r = $urandom_range(0, 99);
      if (remove_heavy)
         kind = (r < 20) ? cht_pkg::REQ_INSERT : (r < 70) ? cht_pkg::REQ_REMOVE :
                (r < 95) ? cht_pkg::REQ_SEARCH : REQ_SPARE;
      else
         kind = (r < 50) ? cht_pkg::REQ_INSERT : (r < 70) ? cht_pkg::REQ_REMOVE :
                (r < 95) ? cht_pkg::REQ_SEARCH : REQ_SPARE;
      return make_request(kind, key, $urandom());
   endfunction

   // Offer one request after a gap and hold it until the block takes it.
   // Valid is only lowered when a gap follows, so a back-to-back request
   // sees a single assignment at the falling edge.
   task automatic send_request(input cht_pkg::req_payload_type r, input int unsigned gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      book.note_request(r);
   endtask

   // Response side: check at the rising edge, choose the next stall at the falling edge
   initial begin
      int unsigned hold_left;
      int unsigned run_left;
      hold_left = 0;
      run_left  = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) book.check_response(rsp_payload);
         @(negedge clock);
         if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left == 0 && run_left == 0) begin
            run_left  = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
            hold_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                     : $urandom_range(20, 60);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
            run_left--;
         end
      end
   end

   // Watchdog: abandon the run after too long without any handshake
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("chained_hash_table_tb: done, errors");
      $finish;
   end

   initial begin
      cht_pkg::req_payload_type  directed_q [$];
      logic [cht_pkg::KEY_W-1:0] drain_keys [$];
      int unsigned               sent;
      int unsigned               b0;
      int unsigned               nb;
      int unsigned               len;
      bit                        remove_heavy;
      bit                        busy;

      // Hold reset, then release it at a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty table, replace, remove, spare code, largest key,
      // one bucket filled to the brim and then reopened
      directed_q.push_back(make_request(cht_pkg::REQ_SEARCH, '0, '0));
      directed_q.push_back(make_request(cht_pkg::REQ_REMOVE, '0, '0));
      directed_q.push_back(make_request(cht_pkg::REQ_INSERT, '0, '0));
      directed_q.push_back(make_request(cht_pkg::REQ_INSERT, '0, {cht_pkg::VALUE_W{1'b1}}));
      directed_q.push_back(make_request(REQ_SPARE, '0, '0));
      directed_q.push_back(make_request(cht_pkg::REQ_REMOVE, '0, '0));
      directed_q.push_back(make_request(cht_pkg::REQ_INSERT, KEY_MAX,
                                        {cht_pkg::VALUE_W{1'b1}}));
      directed_q.push_back(make_request(cht_pkg::REQ_SEARCH, KEY_MAX, '0));
      for (int unsigned k = 0; k < SLOTS_PER_BUCKET; k++)
         directed_q.push_back(make_request(cht_pkg::REQ_INSERT,
                                           cht_pkg::KEY_W'(5 + BUCKETS * k), $urandom()));
      directed_q.push_back(make_request(cht_pkg::REQ_INSERT,
                                        cht_pkg::KEY_W'(5 + BUCKETS * 8), $urandom()));
      directed_q.push_back(make_request(cht_pkg::REQ_SEARCH,
                                        cht_pkg::KEY_W'(5 + BUCKETS * 8), '0));
      directed_q.push_back(make_request(cht_pkg::REQ_REMOVE,
                                        cht_pkg::KEY_W'(5 + BUCKETS * 3), '0));
      directed_q.push_back(make_request(cht_pkg::REQ_INSERT,
                                        cht_pkg::KEY_W'(5 + BUCKETS * 8), $urandom()));
      directed_q.push_back(make_request(cht_pkg::REQ_INSERT,
                                        cht_pkg::KEY_W'(5 + BUCKETS * 8), $urandom()));
      directed_q.push_back(make_request(cht_pkg::REQ_REMOVE, KEY_MAX, '0));
      directed_q.push_back(make_request(REQ_SPARE, KEY_MAX - cht_pkg::KEY_W'(1),
                                        {cht_pkg::VALUE_W{1'b1}}));
      sent = 0;
      foreach (directed_q[i]) begin
         send_request(directed_q[i], next_gap(1'b0));
         sent++;
      end

      // Back-pressure: hold the response side off and keep offering requests
      long_hold_req = 1'b1;
      repeat (40) begin
         send_request(pick_request(0, 3, 1'b0), 0);
         sent++;
      end

      // Random part in chunks, each aimed at a few buckets; now and then
      // drain the table with removes of every live key
      while (sent < TOTAL_ITEMS) begin
         b0           = $urandom_range(0, BUCKETS - 1);
         nb           = $urandom_range(1, 4);
         len          = $urandom_range(60, 160);
         remove_heavy = ($urandom_range(0, 2) == 0);
         busy         = ($urandom_range(0, 3) == 0);
         repeat (len) begin
            if (sent >= TOTAL_ITEMS) break;
            send_request(pick_request(b0, nb, remove_heavy), next_gap(busy));
            sent++;
         end
         if (sent < TOTAL_ITEMS && $urandom_range(0, 2) == 0) begin
            drain_keys.delete();
            foreach (book.slot_live[i])
               if (book.slot_live[i]) drain_keys.push_back(book.slot_key[i]);
            foreach (drain_keys[i]) begin
               if (sent >= TOTAL_ITEMS) break;
               send_request(make_request(cht_pkg::REQ_REMOVE, drain_keys[i], $urandom()),
                            next_gap(busy));
               sent++;
            end
         end
      end

      // Drop valid, wait for the last responses, then let the block settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (book.expected_q.size() != 0) begin
         $error("%0d responses never arrived", book.expected_q.size());
         book.errors++;
      end
      if (book.errors == 0)
         $display("chained_hash_table_tb: done, clean");
      else
         $display("chained_hash_table_tb: done, errors");
      $finish;
   end

endmodule
